>>> hdl/tcw_pkg.sv
// Shared constants, word types and codes for the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int IDX_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int PADDR_W = 3;

  localparam logic [7:0]        NEWLINE_CODE     = 8'd10;
  localparam logic [CELL_W-1:0] BLANK_CELL       = 16'h0720;
  localparam logic [7:0]        TEXT_COLOR_RESET = 8'h07;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register index as seen on paddr[2]
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] cursor_position;
    logic        scrolled;
  } tcw_out_t;

  // result handshake between the sequencer and the output register
  typedef struct packed {
    logic     valid;
    tcw_out_t data;
  } tcw_res_t;

endpackage

>>> hdl/tcw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tcw_core.sv
// Cursor and cell store sequencer: puts, reads, scroll sweep and reset clear.
module tcw_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcw_pkg::tcw_in_t in_data_i,
  input  logic [7:0]       text_color_i,
  input  logic             res_ready_i,
  output tcw_pkg::tcw_res_t res_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [tcw_pkg::IDX_W-1:0]       idx_q;
  logic [tcw_pkg::ROW_W-1:0]       row_q;
  logic [tcw_pkg::COL_W-1:0]       col_q;
  logic                            pend_q;
  logic [tcw_pkg::ADDR_W-1:0]      pend_addr_q;
  logic [tcw_pkg::CELL_W-1:0]      res_data_q;
  logic                            scrolled_q;
  logic                            oor_q;

  logic                            ram_we;
  logic [tcw_pkg::ADDR_W-1:0]      ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]      ram_wdata;
  logic [tcw_pkg::ADDR_W-1:0]      ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]      ram_rdata;

  logic                            accept;
  logic                            is_put;
  logic                            is_newline;
  logic                            wrap;
  logic                            scroll;
  logic [tcw_pkg::ADDR_W-1:0]      cur_addr;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_put     = (in_data_i.kind == tcw_pkg::KIND_PUT);
  assign is_newline = (in_data_i.char_code == tcw_pkg::NEWLINE_CODE);
  assign wrap       = is_newline || (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign scroll     = wrap && (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign cur_addr   = tcw_pkg::ADDR_W'(int'(row_q) * tcw_pkg::COLUMNS + int'(col_q));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[tcw_pkg::ADDR_W-1:0];
    ram_wdata = '0;
    ram_raddr = idx_q[tcw_pkg::ADDR_W-1:0];
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::BLANK_CELL;
      end
      ST_IDLE: begin
        ram_raddr = tcw_pkg::ADDR_W'(in_data_i.cell_address);
        ram_we    = accept && is_put && !is_newline;
        ram_waddr = cur_addr;
        ram_wdata = {text_color_i, in_data_i.char_code};
      end
      ST_COPY: begin
        // write follows the read in the next cycle, one row up (COLUMNS cells lower in the store)
        ram_we    = pend_q;
        ram_waddr = pend_addr_q;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      res_data_q  <= '0;
      scrolled_q  <= 1'b0;
      oor_q       <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - 1)) begin
            idx_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (!is_put) begin
              oor_q      <= (int'(in_data_i.cell_address) >= tcw_pkg::CELL_COUNT);
              scrolled_q <= 1'b0;
              state_q    <= ST_READ;
            end else begin
              res_data_q <= '0;
              scrolled_q <= scroll;
              if (wrap) begin
                col_q <= '0;
                if (!scroll) begin
                  row_q <= row_q + 1'b1;
                end
              end else begin
                col_q <= col_q + 1'b1;
              end
              if (scroll) begin
                idx_q   <= tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
                pend_q  <= 1'b0;
                state_q <= ST_COPY;
              end else begin
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_READ: begin
          res_data_q <= oor_q ? '0 : ram_rdata;
          state_q    <= ST_DONE;
        end
        ST_COPY: begin
          pend_q      <= (int'(idx_q) < tcw_pkg::CELL_COUNT);
          pend_addr_q <= tcw_pkg::ADDR_W'(int'(idx_q) - tcw_pkg::COLUMNS);
          if (idx_q == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT)) begin
            pend_q  <= 1'b0;
            idx_q   <= tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
            state_q <= ST_BLANK;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_BLANK: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid                = (state_q == ST_DONE);
  assign res_o.data.cell_data       = res_data_q;
  assign res_o.data.cursor_position =
    tcw_pkg::POS_W'(int'(row_q) * tcw_pkg::COLUMNS + int'(col_q));
  assign res_o.data.scrolled        = scrolled_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(row_q) < tcw_pkg::ROWS) && (int'(col_q) < tcw_pkg::COLUMNS))
    else $error("cursor left the screen");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("item accepted without leaving idle");

  a_no_write_on_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) || (state_q == ST_DONE)) |-> !ram_we)
    else $error("store written while waiting on a read or result");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && scrolled_q) |->
      ((row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) && (col_q == '0)))
    else $error("scroll did not park cursor at start of bottom row");

  a_copy_ends_in_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COPY) && (idx_q == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT))) |=>
      (state_q == ST_BLANK))
    else $error("scroll copy did not hand over to bottom row clear");

endmodule

>>> hdl/text_console_writer.sv
// Text console writer top: register port, output word register and sequencer.
//
//   channel  | handshake               | word
//   ---------+-------------------------+--------------------------------------
//   in       | in_valid_i / in_stall_o | tcw_in_t  kind, char_code, cell_address
//   out      | out_valid_o/ out_stall_i| tcw_out_t cell_data, cursor_position, scrolled
//   config   | psel/penable/pwrite     | text_color at byte address 0
//
// A put goes straight to its result; a read first makes one registered read of the cell store.
// A put that scrolls walks the store through its single write port: it moves every
// cell below the top row up one row, then clears each cell of the bottom row.
// After reset a clearing pass writes every cell to blank with in_stall_o high;
// register writes are taken throughout.
// The out word sits in a register, so a stalled output holds only the next item.
module text_console_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcw_pkg::tcw_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcw_pkg::tcw_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]        text_color_q;
  logic              out_valid_q;
  tcw_pkg::tcw_out_t out_q;
  tcw_pkg::tcw_res_t res;
  logic              res_ready;
  logic              reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == tcw_pkg::REG_TEXT_COLOR) ? {24'd0, text_color_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::TEXT_COLOR_RESET;
    end else if (reg_write && (paddr[2] == tcw_pkg::REG_TEXT_COLOR)) begin
      text_color_q <= pwdata[7:0];
    end
  end

  // output word register takes a new result when it is empty or its word is taken downstream
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  tcw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .text_color_i(text_color_q),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

endmodule

>>> test/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: shadow screen, random text, reads.
module tb_text_console_writer;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int HOLD_CYCLES = 90;
  localparam logic [tcw_pkg::PADDR_W-1:0] TEXT_COLOR_ADDR = {tcw_pkg::REG_TEXT_COLOR, 2'b00};

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tcw_pkg::tcw_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tcw_pkg::tcw_out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tcw_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // shadow copy of the console
  logic [tcw_pkg::CELL_W-1:0] shadow_cells [tcw_pkg::CELL_COUNT];
  int shadow_row;
  int shadow_col;
  logic [7:0] shadow_color;

  tcw_pkg::tcw_out_t console_replies [$];
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  bit steady_send = 1'b0;
  bit hold_req = 1'b0;

  text_console_writer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] %s: got 0x%0h, predicted 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Applies one word to the shadow console and returns the reply it should produce.
  function automatic tcw_pkg::tcw_out_t console_step(input tcw_pkg::tcw_in_t word);
    tcw_pkg::tcw_out_t r;
    r = '0;
    if (word.kind == tcw_pkg::KIND_READ) begin
      if (word.cell_address < tcw_pkg::CELL_COUNT)
        r.cell_data = shadow_cells[word.cell_address];
    end else begin
      // newline behaves like a put on the last column that writes nothing
      if (word.char_code == tcw_pkg::NEWLINE_CODE) shadow_col = tcw_pkg::COLUMNS - 1;
      else shadow_cells[shadow_row * tcw_pkg::COLUMNS + shadow_col] =
        {shadow_color, word.char_code};
      shadow_col++;
      if (shadow_col >= tcw_pkg::COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= tcw_pkg::ROWS) begin
          for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + tcw_pkg::COLUMNS];
          for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
            shadow_cells[i] = '0;
          shadow_row = tcw_pkg::ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
    end
    r.cursor_position = 11'(shadow_row * tcw_pkg::COLUMNS + shadow_col);
    return r;
  endfunction

  function automatic tcw_pkg::tcw_in_t put_word(input logic [7:0] code);
    tcw_pkg::tcw_in_t w;
    w.kind = tcw_pkg::KIND_PUT;
    w.char_code = code;
    w.cell_address = 11'($urandom_range(0, 2047));
    return w;
  endfunction

  function automatic tcw_pkg::tcw_in_t read_word(input logic [10:0] addr);
    tcw_pkg::tcw_in_t w;
    w.kind = tcw_pkg::KIND_READ;
    w.char_code = 8'($urandom_range(0, 255));
    w.cell_address = addr;
    return w;
  endfunction

  function automatic tcw_pkg::tcw_in_t random_word();
    int pick;
    int here;
    pick = $urandom_range(0, 99);
    here = shadow_row * tcw_pkg::COLUMNS + shadow_col;
    if (pick < 64)
      return put_word(($urandom_range(0, 29) == 0) ? tcw_pkg::NEWLINE_CODE
                                                   : 8'($urandom_range(0, 255)));
    if (pick < 82) return read_word(11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1)));
    // cells just written behind the cursor
    if (pick < 92)
      return read_word(11'((here >= tcw_pkg::COLUMNS)
                           ? here - int'($urandom_range(0, tcw_pkg::COLUMNS))
                           : int'($urandom_range(0, here))));
    if (pick < 96)
      return read_word(11'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS
                           + $urandom_range(0, tcw_pkg::COLUMNS - 1)));
    return read_word(11'($urandom_range(tcw_pkg::CELL_COUNT, 2047)));
  endfunction

  // Offers one word, waits for it to be taken, then maybe idles before the next.
  task automatic send_word(input tcw_pkg::tcw_in_t word);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    console_replies.push_back(console_step(word));
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (console_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write text_color, then read it back; only while the block is idle.
  task automatic set_text_color(input logic [7:0] color);
    logic [31:0] readback;
    wait_for_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TEXT_COLOR_ADDR;
    pwdata <= {24'($urandom), color};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_color = color;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[7:0] !== color)
      report_mismatch("text_color readback", 32'(readback[7:0]), 32'(color));
  endtask

  task automatic test_reset_state();
    send_word(read_word(11'd0));
    send_word(read_word(11'(tcw_pkg::CELL_COUNT - 1)));
    send_word(read_word(11'(tcw_pkg::CELL_COUNT)));
    send_word(read_word(11'h7FF));
  endtask

  task automatic test_put_extremes();
    set_text_color(8'h00);
    send_word(put_word(8'h00));
    set_text_color(8'hFF);
    send_word(put_word(8'hFF));
    set_text_color(tcw_pkg::TEXT_COLOR_RESET);
    send_word(put_word(8'h41));
    send_word(read_word(11'd0));
    send_word(read_word(11'd1));
    send_word(read_word(11'd2));
  endtask

  task automatic test_newline_scroll();
    send_word(put_word(8'h5A));
    repeat (tcw_pkg::ROWS - 1) send_word(put_word(tcw_pkg::NEWLINE_CODE));
    send_word(read_word(11'd0));
    // newline on the bottom row scrolls and clears the bottom row
    send_word(put_word(tcw_pkg::NEWLINE_CODE));
    send_word(read_word(11'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS)));
    send_word(read_word(11'(tcw_pkg::CELL_COUNT - 1)));
  endtask

  task automatic test_random_text(input int count, input logic [7:0] color);
    set_text_color(color);
    repeat (count) send_word(random_word());
  endtask

  task automatic test_output_backpressure();
    set_text_color(8'($urandom_range(0, 255)));
    repeat (100) send_word(random_word());
    // receiver holds off while words keep coming with no gaps
    steady_send = 1'b1;
    hold_req = 1'b1;
    repeat (80) send_word(random_word());
    steady_send = 1'b0;
    repeat (120) send_word(random_word());
  endtask

  task automatic test_sender_pause();
    set_text_color(8'h00);
    repeat (150) send_word(random_word());
    wait_for_results();
    repeat (150) send_word(random_word());
  endtask

  always @(posedge clk_i) begin : check_replies
    tcw_pkg::tcw_out_t want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (console_replies.size() == 0) begin
        report_mismatch("word without prediction", 32'(out_data_o), 32'd0);
      end else begin
        want = console_replies.pop_front();
        if (out_data_o.cell_data !== want.cell_data)
          report_mismatch("cell_data", 32'(out_data_o.cell_data), 32'(want.cell_data));
        if (out_data_o.cursor_position !== want.cursor_position)
          report_mismatch("cursor_position", 32'(out_data_o.cursor_position),
                          32'(want.cursor_position));
        if (out_data_o.scrolled !== want.scrolled)
          report_mismatch("scrolled", 32'(out_data_o.scrolled), 32'(want.scrolled));
      end
    end
  end

  // Receiver stall pattern, with a long hold on request.
  initial begin : out_stall_pattern
    int stretch;
    int mode;
    int held;
    forever begin
      stretch = $urandom_range(8, 64);
      mode = $urandom_range(0, 3);
      repeat (stretch) begin
        @(posedge clk_i);
        if (hold_req) begin
          out_stall_i <= 1'b1;
          held = 0;
          while (held < HOLD_CYCLES) begin
            @(posedge clk_i);
            held++;
          end
          hold_req = 1'b0;
        end
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  initial begin : cycle_watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
    shadow_row = 0;
    shadow_col = 0;
    shadow_color = tcw_pkg::TEXT_COLOR_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_put_extremes();
    test_newline_scroll();
    test_random_text(350, 8'($urandom_range(0, 255)));
    test_output_backpressure();
    test_sender_pause();
    test_random_text(350, 8'hFF);

    wait_for_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && console_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_core.sv
hdl/text_console_writer.sv
test/tb_text_console_writer.sv
